[design/mmss_pkg.sv]
// Shared types and constants of the masked multi-signature scanner.
package mmss_pkg;

  // Field widths of the input and result words.
  localparam int SIG_IDX_W    = 3;
  localparam int POS_FIELD_W  = 5;
  localparam int LEN_FIELD_W  = 6;
  localparam int ADDR_FIELD_W = 32;
  localparam int SLOT_W       = 4;

  // Stream word widths; the tdata words are padded to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // Signature codes that the sig_index field can name.
  localparam int NUM_SIG_CODES = 2 ** SIG_IDX_W;

  // Result list carried with every scanned byte.
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = 4;
  localparam int RES_IDX_W   = 3;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_NUM_SIGS = 1'b0;
  localparam logic [3:0] NUM_SIGS_RESET = 4'd8;

  // Byte masks for the care bit.
  localparam logic [7:0] BYTE_ALL  = 8'hFF;
  localparam logic [7:0] BYTE_NONE = 8'h00;

  // Input word kinds.
  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_SET_LEN = 2'd1,
    FUNC_SCAN    = 2'd2,
    FUNC_BREAK   = 2'd3
  } func_t;

  // One reported match.
  typedef struct packed {
    logic                    stored;
    logic [SLOT_W-1:0]       slot;
    logic [ADDR_FIELD_W-1:0] match_address;
    logic [SIG_IDX_W-1:0]    match_sig;
  } result_t;

  // One input word on its way down the chain, with the matches found so far.
  typedef struct packed {
    logic                             valid;
    func_t                            func;
    logic [SIG_IDX_W-1:0]             sig_index;
    logic [POS_FIELD_W-1:0]           position;
    logic [7:0]                       value;
    logic                             care;
    logic [LEN_FIELD_W-1:0]           sig_length;
    logic [ADDR_FIELD_W-1:0]          address;
    logic [RES_CNT_W-1:0]             res_count;
    result_t [MAX_RESULTS-1:0]        results;
  } stage_t;

endpackage

[design/mmss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mmss_cell.sv]
// One signature cell: pattern store, position, length and match count of one signature.
module mmss_cell #(
  parameter int IDX         = 0,
  parameter int MAX_LEN     = 32,
  parameter int MAX_MATCHES = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [3:0]       num_sigs,
  input  mmss_pkg::stage_t stage_i,
  output mmss_pkg::stage_t stage_o
);

  import mmss_pkg::*;

  localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = LEN_W + 1;
  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam int PAT_W = 9;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  stage_t           stage_r, stage_nxt;

  logic             wr_en;
  logic [POS_W-1:0] wr_addr;
  logic [PAT_W-1:0] wr_data;
  logic [PAT_W-1:0] ram_rdata;
  logic             byp_r;
  logic [PAT_W-1:0] byp_data_r;
  logic [PAT_W-1:0] pat_word;
  logic [7:0]       care_mask;
  logic             byte_eq;
  logic             sel;
  logic             scan_on;
  logic             pos_ok;
  logic [CMP_W-1:0] pos_inc;
  logic             full;
  logic             hit;
  logic             matched;
  logic [LEN_W-1:0] len_clamped;
  logic [ADDR_WIDTH-1:0] start_addr;
  result_t          entry;

  // Pattern byte and care bit for every position of this signature.
  mmss_ram #(
    .WIDTH(PAT_W),
    .DEPTH(MAX_LEN)
  ) u_pat_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(pos_nxt),
    .rdata(ram_rdata)
  );

  // Forward a pattern write that lands on the entry being fetched.
  always_ff @(posedge clk) begin
    byp_r      <= wr_en && (wr_addr == pos_nxt);
    byp_data_r <= wr_data;
  end

  assign pat_word  = byp_r ? byp_data_r : ram_rdata;
  assign care_mask = pat_word[8] ? BYTE_ALL : BYTE_NONE;
  assign byte_eq   = (stage_i.value & care_mask) == (pat_word[7:0] & care_mask);

  // Addressing of this cell.
  assign hit     = stage_i.valid && en;
  assign sel     = (IDX < NUM_SIG_CODES) && (stage_i.sig_index == SIG_IDX_W'(IDX));
  assign scan_on = IDX < int'(num_sigs);
  assign pos_ok  = int'(stage_i.position) < MAX_LEN;
  assign pos_inc = CMP_W'(pos_r) + CMP_W'(1);
  assign full    = pos_inc >= CMP_W'(len_r);

  assign wr_en   = hit && (stage_i.func == FUNC_WRITE) && sel && pos_ok;
  assign wr_addr = POS_W'(stage_i.position);
  assign wr_data = {stage_i.care, stage_i.value};

  // Length clamped to the range one through MAX_LEN.
  always_comb begin
    if (stage_i.sig_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (int'(stage_i.sig_length) > MAX_LEN) begin
      len_clamped = LEN_W'(MAX_LEN);
    end else begin
      len_clamped = LEN_W'(stage_i.sig_length);
    end
  end

  assign start_addr = ADDR_WIDTH'(stage_i.address) + ADDR_WIDTH'(1) - ADDR_WIDTH'(len_r);

  // State update and result append for the word passing this cell.
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    matched   = 1'b0;
    entry.match_sig     = SIG_IDX_W'(IDX);
    entry.match_address = ADDR_FIELD_W'(start_addr);
    entry.slot          = '0;
    entry.stored        = 1'b0;
    if (hit) begin
      case (stage_i.func)
        FUNC_WRITE: begin
        end
        FUNC_SET_LEN: begin
          if (sel) begin
            len_nxt = len_clamped;
            pos_nxt = '0;
            cnt_nxt = '0;
          end
        end
        FUNC_SCAN: begin
          if (scan_on) begin
            if (!byte_eq) begin
              pos_nxt = '0;
            end else if (!full) begin
              pos_nxt = POS_W'(pos_inc);
            end else begin
              pos_nxt = '0;
              matched = 1'b1;
              if (int'(cnt_r) < MAX_MATCHES) begin
                entry.stored = 1'b1;
                entry.slot   = SLOT_W'(cnt_r);
                cnt_nxt      = cnt_r + CNT_W'(1);
              end
            end
          end
        end
        FUNC_BREAK: begin
          pos_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    stage_nxt = stage_i;
    if (matched && (int'(stage_i.res_count) < MAX_RESULTS)) begin
      stage_nxt.results[RES_IDX_W'(stage_i.res_count)] = entry;
      stage_nxt.res_count = stage_i.res_count + RES_CNT_W'(1);
    end
  end

  // Signature state and the stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      len_r         <= LEN_W'(1);
      cnt_r         <= '0;
      stage_r.valid <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      if (en) begin
        stage_r <= stage_nxt;
      end
    end
  end

  assign stage_o = stage_r;

endmodule

[design/mmss_drain.sv]
// Result buffer at the end of the chain: hands out the matches of one byte, one word a cycle while out_tready is high.
module mmss_drain (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  mmss_pkg::stage_t                    last_stage,
  output logic                                can_take,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mmss_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  import mmss_pkg::*;

  logic                      busy_r;
  logic [RES_CNT_W-1:0]      cnt_r;
  logic [RES_IDX_W-1:0]      idx_r;
  result_t [MAX_RESULTS-1:0] list_r;
  result_t                   cur;
  logic                      is_last;

  assign cur      = list_r[idx_r];
  assign is_last  = (RES_CNT_W'(idx_r) + RES_CNT_W'(1)) == cnt_r;
  assign can_take = !busy_r || (out_tready && is_last);

  // Load a new result list, or step through the current one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= last_stage.res_count != '0;
      idx_r  <= '0;
    end else if (busy_r && out_tready) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r <= last_stage.results;
      cnt_r  <= last_stage.res_count;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = is_last;
  assign out_tdata  = {cur.stored, cur.slot, cur.match_address, cur.match_sig};

endmodule

[design/masked_multi_signature_scanner.sv]
// Top level of the masked multi-signature scanner: input word, cell chain, result buffer.
//
//  Channel  Dir  Handshake                     Contents
//  in_      in   in_tvalid / in_tready         pattern writes, length sets, data bytes, breaks
//  out_     out  out_tvalid / out_tready       one completed match per word, tlast on the last
//  cfg_     in   APB psel/penable, pready=1    num_signatures at byte address 0
//
// One input word is taken each cycle that in_tready is high; it walks the chain one cell
// a cycle while the chain moves. A byte with matches holds the result buffer until its
// result words, one per match, are taken; while it is full and not draining, the whole
// chain and in_tready hold. Reset clears positions and counts and sets lengths to one;
// the pattern stores are not cleared and must be written before they are scanned.
module masked_multi_signature_scanner #(
  parameter int NUM_SIGS    = 8,
  parameter int MAX_LEN     = 32,
  parameter int MAX_MATCHES = 16,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: sig_index[2:0], position[7:3], value[15:8], care[16],
  //           sig_length[22:17], address[54:23], zero pad[55]
  // in_tuser: func[1:0]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mmss_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [mmss_pkg::IN_TUSER_W-1:0]    in_tuser,
  // out_tdata: match_sig[2:0], match_address[34:3], slot[38:35], stored[39]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mmss_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mmss_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mmss_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mmss_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import mmss_pkg::*;

  logic [3:0] num_sigs_r;
  logic       reg_idx;
  logic       cfg_wr;
  logic       en;
  logic       can_take;
  stage_t     chain [NUM_SIGS+1];

  // Configuration register.
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_NUM_SIGS) ? CFG_DATA_W'(num_sigs_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sigs_r <= NUM_SIGS_RESET;
    end else if (cfg_wr && (reg_idx == REG_NUM_SIGS)) begin
      num_sigs_r <= cfg_pwdata[3:0];
    end
  end

  // The chain moves as a whole whenever its last stage is empty or its last word can leave.
  assign en        = !chain[NUM_SIGS].valid || can_take;
  assign in_tready = en;

  // Unpack the input word at the head of the chain.
  always_comb begin
    chain[0].valid      = in_tvalid;
    chain[0].func       = func_t'(in_tuser[1:0]);
    chain[0].sig_index  = in_tdata[2:0];
    chain[0].position   = in_tdata[7:3];
    chain[0].value      = in_tdata[15:8];
    chain[0].care       = in_tdata[16];
    chain[0].sig_length = in_tdata[22:17];
    chain[0].address    = in_tdata[54:23];
    chain[0].res_count  = '0;
    chain[0].results    = '0;
  end

  // One cell per signature, in signature order.
  for (genvar g = 0; g < NUM_SIGS; g++) begin : g_cell
    mmss_cell #(
      .IDX        (g),
      .MAX_LEN    (MAX_LEN),
      .MAX_MATCHES(MAX_MATCHES),
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .num_sigs(num_sigs_r),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // Result words out, one per cycle while out_tready is high.
  mmss_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (en && chain[NUM_SIGS].valid),
    .last_stage(chain[NUM_SIGS]),
    .can_take  (can_take),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
